[src/ffha_pkg.sv]
// Shared types and constants of the first-fit heap allocator.
`timescale 1ns / 1ps
package ffha_pkg;

    // Result status codes.
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BAD_ARG = 2'd1;
    localparam logic [1:0] ST_UNKNOWN = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    // Request function codes.
    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    localparam logic [31:0] HEAP_BASE_RESET = 32'h1000_0000;
    localparam logic [23:0] SIZE_MAX_ALIGN  = 24'hFF_FFFC;
    localparam logic [25:0] SIZE_MAX24      = 26'h0FF_FFFF;
    localparam logic [25:0] MIN_SPLIT_AREA  = 26'd4;

    // Commands from the controller to the datapath.
    typedef enum logic [4:0] {
        CMD_NOP,
        CMD_LOAD,
        CMD_CHECK,
        CMD_U_SCAN,
        CMD_F_RD,
        CMD_F_EV,
        CMD_REM_RD,
        CMD_REM_EV,
        CMD_BRK,
        CMD_USED_WR,
        CMD_U_RD,
        CMD_U_EV,
        CMD_BRK_CHK,
        CMD_P_RD,
        CMD_P_EV,
        CMD_MERGE,
        CMD_MERGE2,
        CMD_APPLY,
        CMD_INS_RD,
        CMD_INS_EV,
        CMD_FINISH
    } t_cmd;

    // Status flags from the datapath to the controller.
    typedef struct packed {
        logic func;
        logic bad;
        logic u_free;
        logic u_match;
        logic u_last;
        logic at_end;
        logic fit;
        logic split;
        logic at_brk;
        logic below;
        logic m_next;
        logic m_prev;
        logic full;
        logic at_pos;
    } t_stat;

endpackage

[src/ffha_ctrl.sv]
// Controller state machine of the first-fit heap allocator.
`timescale 1ns / 1ps
module ffha_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  ffha_pkg::t_stat     i_stat,
    output ffha_pkg::t_cmd      o_cmd,
    output logic                o_busy,
    output logic                o_done
);

    typedef enum logic [4:0] {
        S_IDLE, S_CHECK, S_USCAN, S_FRD, S_FEV, S_REMRD, S_REMEV, S_BRK, S_UWR,
        S_URD, S_UEV, S_BCHK, S_PRD, S_PEV, S_MRG, S_MRG2, S_APPLY, S_INSRD,
        S_INSEV, S_FIN
    } t_state;

    t_state r_state;
    logic   r_done;

    // Command for the datapath follows the current state.
    always_comb begin
        unique case (r_state)
            S_IDLE:  o_cmd = i_start ? ffha_pkg::CMD_LOAD : ffha_pkg::CMD_NOP;
            S_CHECK: o_cmd = ffha_pkg::CMD_CHECK;
            S_USCAN: o_cmd = ffha_pkg::CMD_U_SCAN;
            S_FRD:   o_cmd = ffha_pkg::CMD_F_RD;
            S_FEV:   o_cmd = ffha_pkg::CMD_F_EV;
            S_REMRD: o_cmd = ffha_pkg::CMD_REM_RD;
            S_REMEV: o_cmd = ffha_pkg::CMD_REM_EV;
            S_BRK:   o_cmd = ffha_pkg::CMD_BRK;
            S_UWR:   o_cmd = ffha_pkg::CMD_USED_WR;
            S_URD:   o_cmd = ffha_pkg::CMD_U_RD;
            S_UEV:   o_cmd = ffha_pkg::CMD_U_EV;
            S_BCHK:  o_cmd = ffha_pkg::CMD_BRK_CHK;
            S_PRD:   o_cmd = ffha_pkg::CMD_P_RD;
            S_PEV:   o_cmd = ffha_pkg::CMD_P_EV;
            S_MRG:   o_cmd = ffha_pkg::CMD_MERGE;
            S_MRG2:  o_cmd = ffha_pkg::CMD_MERGE2;
            S_APPLY: o_cmd = ffha_pkg::CMD_APPLY;
            S_INSRD: o_cmd = ffha_pkg::CMD_INS_RD;
            S_INSEV: o_cmd = ffha_pkg::CMD_INS_EV;
            S_FIN:   o_cmd = ffha_pkg::CMD_FINISH;
            default: o_cmd = ffha_pkg::CMD_NOP;
        endcase
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = r_done;

    // State register and the result strobe.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_IDLE:  if (i_start) r_state <= S_CHECK;
                S_CHECK: begin
                    if (i_stat.bad) r_state <= S_FIN;
                    else if (i_stat.func == ffha_pkg::FUNC_ALLOC) r_state <= S_USCAN;
                    else r_state <= S_URD;
                end
                S_USCAN: begin
                    if (i_stat.u_free) r_state <= S_FRD;
                    else if (i_stat.u_last) r_state <= S_FIN;
                end
                S_FRD:   r_state <= i_stat.at_end ? S_BRK : S_FEV;
                S_FEV: begin
                    if (i_stat.fit) r_state <= i_stat.split ? S_UWR : S_REMRD;
                    else r_state <= S_FRD;
                end
                S_REMRD: begin
                    if (!i_stat.at_end) r_state <= S_REMEV;
                    else if (i_stat.func == ffha_pkg::FUNC_FREE) r_state <= S_FIN;
                    else r_state <= S_UWR;
                end
                S_REMEV: r_state <= S_REMRD;
                S_BRK:   r_state <= S_UWR;
                S_UWR:   r_state <= S_FIN;
                S_URD:   r_state <= S_UEV;
                S_UEV: begin
                    if (i_stat.u_match) r_state <= S_BCHK;
                    else if (i_stat.u_last) r_state <= S_FIN;
                    else r_state <= S_URD;
                end
                S_BCHK:  r_state <= i_stat.at_brk ? S_FIN : S_PRD;
                S_PRD:   r_state <= i_stat.at_end ? S_MRG : S_PEV;
                S_PEV:   r_state <= i_stat.below ? S_PRD : S_MRG;
                S_MRG:   r_state <= S_MRG2;
                S_MRG2:  r_state <= S_APPLY;
                S_APPLY: begin
                    if (i_stat.full) r_state <= S_FIN;
                    else if (i_stat.m_prev) r_state <= i_stat.m_next ? S_REMRD : S_FIN;
                    else if (i_stat.m_next) r_state <= S_FIN;
                    else r_state <= S_INSRD;
                end
                S_INSRD: r_state <= i_stat.at_pos ? S_FIN : S_INSEV;
                S_INSEV: r_state <= S_INSRD;
                S_FIN: begin
                    r_state <= S_IDLE;
                    r_done  <= 1'b1;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

[src/ffha_dp.sv]
// Datapath of the first-fit heap allocator: tables, break and result registers.
`timescale 1ns / 1ps
module ffha_dp #(
    parameter int FREE_SLOTS   = 64,
    parameter int USED_SLOTS   = 64,
    parameter int HEADER_BYTES = 12
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ffha_pkg::t_cmd     i_cmd,
    output ffha_pkg::t_stat    o_stat,
    input  logic               i_func,
    input  logic [23:0]        i_req_size,
    input  logic [31:0]        i_release_addr,
    input  logic               i_cfg_valid,
    input  logic [31:0]        i_cfg_data,
    output logic [31:0]        o_result_addr,
    output logic [1:0]         o_status,
    output logic [31:0]        o_break_addr
);

    localparam int MAXS = (FREE_SLOTS > USED_SLOTS) ? FREE_SLOTS : USED_SLOTS;
    localparam int CW   = $clog2(MAXS + 1);
    localparam int FAW  = $clog2(FREE_SLOTS);
    localparam int UAW  = $clog2(USED_SLOTS);
    localparam logic [31:0] HDR32 = 32'(HEADER_BYTES);
    localparam logic [25:0] HDR26 = 26'(HEADER_BYTES);

    // Table memories.
    logic [31:0] r_fa_mem [FREE_SLOTS];
    logic [23:0] r_fs_mem [FREE_SLOTS];
    logic [31:0] r_ua_mem [USED_SLOTS];
    logic [23:0] r_us_mem [USED_SLOTS];
    logic [USED_SLOTS-1:0] r_uvalid;

    logic [31:0] r_fa_q, r_ua_q;
    logic [23:0] r_fs_q, r_us_q;

    logic          r_func;
    logic [23:0]   r_req;
    logic [31:0]   r_area, r_hdr, r_bp, r_res;
    logic [23:0]   r_usize, r_s2, r_prev_size, r_next_size;
    logic [31:0]   r_prev_addr, r_next_addr;
    logic [CW-1:0] r_idx, r_pos, r_count;
    logic [UAW-1:0] r_slot;
    logic          r_has_prev, r_has_next, r_mn, r_mp;
    logic [1:0]    r_st;

    logic [23:0]   w_need;
    logic [25:0]   w_next_sum, w_prev_sum;
    logic [23:0]   w_rest;
    logic [CW-1:0] w_idx_m1, w_pos_m1, w_rd_idx, w_wr_idx;
    logic          w_f_we;
    logic [31:0]   w_f_wa;
    logic [23:0]   w_f_ws;

    // Aligned size; only used when the request is in range.
    assign w_need     = (r_req + 24'd3) & ~24'd3;
    assign w_rest     = r_fs_q - HDR26[23:0] - w_need;
    assign w_next_sum = {2'b0, r_usize} + HDR26 + {2'b0, r_next_size};
    assign w_prev_sum = {2'b0, r_prev_size} + HDR26 + {2'b0, r_s2};
    assign w_idx_m1   = r_idx - CW'(1);
    assign w_pos_m1   = r_pos - CW'(1);
    assign w_rd_idx   = (i_cmd == ffha_pkg::CMD_INS_RD) ? w_idx_m1 : r_idx;

    // Status flags for the controller.
    always_comb begin
        o_stat.func    = r_func;
        o_stat.bad     = (r_func == ffha_pkg::FUNC_ALLOC)
                         ? ((r_req == 24'd0) || (r_req > ffha_pkg::SIZE_MAX_ALIGN))
                         : (r_area == 32'd0);
        o_stat.u_free  = !r_uvalid[r_idx[UAW-1:0]];
        o_stat.u_match = r_uvalid[r_idx[UAW-1:0]] && (r_ua_q == r_area);
        o_stat.u_last  = (r_idx == CW'(USED_SLOTS - 1));
        o_stat.at_end  = (r_idx >= r_count);
        o_stat.fit     = (r_fs_q >= w_need);
        o_stat.split   = ({2'b0, r_fs_q} >= ({2'b0, w_need} + HDR26 +
                          ffha_pkg::MIN_SPLIT_AREA));
        o_stat.at_brk  = (r_bp == (r_area + {8'd0, r_usize}));
        o_stat.below   = (r_fa_q < r_hdr);
        o_stat.m_next  = r_mn;
        o_stat.m_prev  = r_mp;
        o_stat.full    = !r_mn && !r_mp && (r_count >= CW'(FREE_SLOTS));
        o_stat.at_pos  = (r_idx == r_pos);
    end

    // Free table write port.
    always_comb begin
        w_f_we   = 1'b0;
        w_wr_idx = r_idx;
        w_f_wa   = r_fa_q;
        w_f_ws   = r_fs_q;
        unique case (i_cmd)
            ffha_pkg::CMD_F_EV: begin
                if (o_stat.fit && o_stat.split) begin
                    w_f_we = 1'b1;
                    w_f_ws = w_rest;
                end
            end
            ffha_pkg::CMD_REM_EV: begin
                w_f_we   = 1'b1;
                w_wr_idx = w_idx_m1;
            end
            ffha_pkg::CMD_APPLY: begin
                if (!o_stat.full && r_mp) begin
                    w_f_we   = 1'b1;
                    w_wr_idx = w_pos_m1;
                    w_f_wa   = r_prev_addr;
                    w_f_ws   = w_prev_sum[23:0];
                end else if (!o_stat.full && r_mn) begin
                    w_f_we   = 1'b1;
                    w_wr_idx = r_pos;
                    w_f_wa   = r_hdr;
                    w_f_ws   = r_s2;
                end
            end
            ffha_pkg::CMD_INS_RD: begin
                if (o_stat.at_pos) begin
                    w_f_we = 1'b1;
                    w_f_wa = r_hdr;
                    w_f_ws = r_usize;
                end
            end
            ffha_pkg::CMD_INS_EV: w_f_we = 1'b1;
            default: w_f_we = 1'b0;
        endcase
    end

    // Memories with registered reads.
    always_ff @(posedge i_clk) begin
        r_fa_q <= r_fa_mem[w_rd_idx[FAW-1:0]];
        r_fs_q <= r_fs_mem[w_rd_idx[FAW-1:0]];
        r_ua_q <= r_ua_mem[r_idx[UAW-1:0]];
        r_us_q <= r_us_mem[r_idx[UAW-1:0]];
        if (w_f_we) begin
            r_fa_mem[w_wr_idx[FAW-1:0]] <= w_f_wa;
            r_fs_mem[w_wr_idx[FAW-1:0]] <= w_f_ws;
        end
        if (i_cmd == ffha_pkg::CMD_USED_WR) begin
            r_ua_mem[r_slot] <= r_hdr + HDR32;
            r_us_mem[r_slot] <= r_usize;
        end
    end

    // Control state: valid bits, fill count and break.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_uvalid <= '0;
            r_count  <= '0;
            r_bp     <= ffha_pkg::HEAP_BASE_RESET;
        end else begin
            if (i_cfg_valid) r_bp <= i_cfg_data;
            unique case (i_cmd)
                ffha_pkg::CMD_REM_RD: if (o_stat.at_end) r_count <= r_count - CW'(1);
                ffha_pkg::CMD_BRK:    r_bp <= r_bp + HDR32 + {8'd0, w_need};
                ffha_pkg::CMD_USED_WR: r_uvalid[r_slot] <= 1'b1;
                ffha_pkg::CMD_BRK_CHK: begin
                    if (o_stat.at_brk) begin
                        r_bp             <= r_bp - HDR32 - {8'd0, r_usize};
                        r_uvalid[r_slot] <= 1'b0;
                    end
                end
                ffha_pkg::CMD_APPLY: if (!o_stat.full) r_uvalid[r_slot] <= 1'b0;
                ffha_pkg::CMD_INS_RD: if (o_stat.at_pos) r_count <= r_count + CW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    // Working registers of one request.
    always_ff @(posedge i_clk) begin
        unique case (i_cmd)
            ffha_pkg::CMD_LOAD: begin
                r_func <= i_func;
                r_req  <= i_req_size;
                r_area <= i_release_addr;
                r_res  <= 32'd0;
                r_st   <= ffha_pkg::ST_OK;
                r_idx  <= '0;
            end
            ffha_pkg::CMD_CHECK: if (o_stat.bad) r_st <= ffha_pkg::ST_BAD_ARG;
            ffha_pkg::CMD_U_SCAN: begin
                if (o_stat.u_free) begin
                    r_slot <= r_idx[UAW-1:0];
                    r_idx  <= '0;
                end else if (o_stat.u_last) begin
                    r_st <= ffha_pkg::ST_FULL;
                end else begin
                    r_idx <= r_idx + CW'(1);
                end
            end
            ffha_pkg::CMD_F_EV: begin
                if (o_stat.fit && o_stat.split) begin
                    r_hdr   <= r_fa_q + HDR32 + {8'd0, w_rest};
                    r_usize <= w_need;
                end else if (o_stat.fit) begin
                    r_hdr   <= r_fa_q;
                    r_usize <= r_fs_q;
                    r_idx   <= r_idx + CW'(1);
                end else begin
                    r_idx <= r_idx + CW'(1);
                end
            end
            ffha_pkg::CMD_REM_EV: r_idx <= r_idx + CW'(1);
            ffha_pkg::CMD_BRK: begin
                r_hdr   <= r_bp;
                r_usize <= w_need;
            end
            ffha_pkg::CMD_USED_WR: r_res <= r_hdr + HDR32;
            ffha_pkg::CMD_U_EV: begin
                if (o_stat.u_match) begin
                    r_slot  <= r_idx[UAW-1:0];
                    r_usize <= r_us_q;
                    r_hdr   <= r_area - HDR32;
                end else if (o_stat.u_last) begin
                    r_st <= ffha_pkg::ST_UNKNOWN;
                end else begin
                    r_idx <= r_idx + CW'(1);
                end
            end
            ffha_pkg::CMD_BRK_CHK: begin
                r_idx      <= '0;
                r_has_prev <= 1'b0;
            end
            ffha_pkg::CMD_P_RD: begin
                if (o_stat.at_end) begin
                    r_has_next <= 1'b0;
                    r_pos      <= r_idx;
                end
            end
            ffha_pkg::CMD_P_EV: begin
                if (o_stat.below) begin
                    r_prev_addr <= r_fa_q;
                    r_prev_size <= r_fs_q;
                    r_has_prev  <= 1'b1;
                    r_idx       <= r_idx + CW'(1);
                end else begin
                    r_next_addr <= r_fa_q;
                    r_next_size <= r_fs_q;
                    r_has_next  <= 1'b1;
                    r_pos       <= r_idx;
                end
            end
            ffha_pkg::CMD_MERGE: begin
                r_mn <= r_has_next && ((r_area + {8'd0, r_usize}) == r_next_addr) &&
                        (w_next_sum <= ffha_pkg::SIZE_MAX24);
                r_s2 <= (r_has_next && ((r_area + {8'd0, r_usize}) == r_next_addr) &&
                        (w_next_sum <= ffha_pkg::SIZE_MAX24)) ? w_next_sum[23:0] : r_usize;
            end
            ffha_pkg::CMD_MERGE2: begin
                r_mp <= r_has_prev &&
                        ((r_prev_addr + HDR32 + {8'd0, r_prev_size}) == r_hdr) &&
                        (w_prev_sum <= ffha_pkg::SIZE_MAX24);
            end
            ffha_pkg::CMD_APPLY: begin
                if (o_stat.full) r_st <= ffha_pkg::ST_FULL;
                else if (r_mp) r_idx <= r_pos + CW'(1);
                else r_idx <= r_count;
            end
            ffha_pkg::CMD_INS_EV: r_idx <= w_idx_m1;
            default: r_idx <= r_idx;
        endcase
    end

    // Result registers, loaded as the request completes.
    always_ff @(posedge i_clk) begin
        if (i_cmd == ffha_pkg::CMD_FINISH) begin
            o_result_addr <= r_res;
            o_status      <= r_st;
            o_break_addr  <= r_bp;
        end
    end

endmodule

[src/first_fit_heap_allocator_top.sv]
// Top level of the first-fit heap allocator with coalescing of freed blocks.
//
// Requests enter on i_start with i_func, i_req_size and i_release_addr; a
// transaction is taken at a rising edge with i_start high and o_busy low.
// One result per request appears on o_result_addr, o_status and
// o_break_addr, marked by o_done for a single cycle; the receiver cannot
// stall it. An allocate scans the used-slot valid bits one per cycle, then
// reads the free table entry by entry through its registered read port; a
// whole-block take shifts the entries after the hit, so scan and shift
// together cover the table once. A rejected request goes straight from the
// check to the finish. A free scans the used table, lowers the break if the
// block ends there, else scans the free table up to the insert point and
// shifts the rest when it merges on neither side or on both. One request is
// in work at a time; the next may start in the cycle that o_done is high.
// The heap_base register is written on i_cfg_valid (o_cfg_ready is always
// high) and reloads the break; the tables are kept.
// Reset empties both tables and sets the break to 0x10000000; no clearing
// pass is needed.
`timescale 1ns / 1ps
module first_fit_heap_allocator_top #(
    parameter int FREE_SLOTS   = 64,
    parameter int USED_SLOTS   = 64,
    parameter int HEADER_BYTES = 12
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic        i_func,
    input  logic [23:0] i_req_size,
    input  logic [31:0] i_release_addr,
    output logic        o_done,
    output logic [31:0] o_result_addr,
    output logic [1:0]  o_status,
    output logic [31:0] o_break_addr,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data
);

    ffha_pkg::t_cmd  w_cmd;
    ffha_pkg::t_stat w_stat;

    // Configuration writes are taken at any time.
    assign o_cfg_ready = 1'b1;

    // Sequencer.
    ffha_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd),
        .o_busy  (o_busy),
        .o_done  (o_done)
    );

    // Tables and arithmetic.
    ffha_dp #(
        .FREE_SLOTS   (FREE_SLOTS),
        .USED_SLOTS   (USED_SLOTS),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .i_func         (i_func),
        .i_req_size     (i_req_size),
        .i_release_addr (i_release_addr),
        .i_cfg_valid    (i_cfg_valid && o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .o_result_addr  (o_result_addr),
        .o_status       (o_status),
        .o_break_addr   (o_break_addr)
    );

`ifndef SYNTH
    // A result only follows a request in work.
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(o_busy))
        else $error("result strobe without a request in work");

    // The strobe lasts a single cycle.
    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe longer than one cycle");

    // A failed request returns no area address.
    a_fail_no_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status != ffha_pkg::ST_OK)) |-> (o_result_addr == 32'd0))
        else $error("failed request returned an address");
`endif

endmodule

[bench/ffha_checker.sv]
// Scoreboard of the heap allocator: tracks the heap state and checks each result.
`timescale 1ns / 1ps
module ffha_checker #(
    parameter int FREE_SLOTS   = 64,
    parameter int USED_SLOTS   = 64,
    parameter int HEADER_BYTES = 12
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_busy,
    input  logic        i_func,
    input  logic [23:0] i_req_size,
    input  logic [31:0] i_release_addr,
    input  logic        i_done,
    input  logic [31:0] i_result_addr,
    input  logic [1:0]  i_status,
    input  logic [31:0] i_break_addr,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [31:0] i_cfg_data,
    output int          o_errors,
    output int          o_pending
);

    localparam logic [31:0] HDR = 32'(HEADER_BYTES);

    typedef struct {
        logic [31:0] area;
        logic [1:0]  status;
        logic [31:0] brk;
    } t_heap_reply;

    // Mirror of the allocator state.
    logic [31:0] free_hdr  [FREE_SLOTS];
    logic [31:0] free_len  [FREE_SLOTS];
    int          free_cnt;
    logic [31:0] used_area [USED_SLOTS];
    logic [31:0] used_len  [USED_SLOTS];
    logic        used_ok   [USED_SLOTS];
    logic [31:0] brk;

    t_heap_reply replies_due[$];

    assign o_pending = replies_due.size();

    // Removes one free entry and closes the gap.
    function automatic void drop_free_entry(input int pos);
        for (int i = pos; i + 1 < free_cnt; i++) begin
            free_hdr[i] = free_hdr[i + 1];
            free_len[i] = free_len[i + 1];
        end
        free_cnt--;
    endfunction

    function automatic void predict_alloc(input logic [23:0] req,
                                          output logic [31:0] area,
                                          output logic [1:0] st);
        logic [31:0] need;
        logic [31:0] fsz;
        logic [31:0] rest;
        logic [31:0] hdr;
        int slot;
        int i;
        area = '0;
        if (req == 0) begin
            st = ffha_pkg::ST_BAD_ARG;
            return;
        end
        need = ({8'd0, req} + 32'd3) & ~32'd3;
        if (need > 32'h00FF_FFFC) begin
            st = ffha_pkg::ST_BAD_ARG;
            return;
        end
        slot = -1;
        for (int k = USED_SLOTS - 1; k >= 0; k--)
            if (!used_ok[k]) slot = k;
        if (slot < 0) begin
            st = ffha_pkg::ST_FULL;
            return;
        end
        // First fit over the address-ordered free table.
        i = 0;
        while (i < free_cnt && free_len[i] < need) i++;
        if (i < free_cnt) begin
            fsz = free_len[i];
            if (fsz - need >= HDR + 32'd4) begin
                rest = fsz - HDR - need;
                free_len[i] = rest;
                hdr = free_hdr[i] + HDR + rest;
                used_len[slot] = need;
            end else begin
                hdr = free_hdr[i];
                used_len[slot] = fsz;
                drop_free_entry(i);
            end
        end else begin
            hdr = brk;
            brk = brk + HDR + need;
            used_len[slot] = need;
        end
        used_area[slot] = hdr + HDR;
        used_ok[slot] = 1'b1;
        area = used_area[slot];
        st = ffha_pkg::ST_OK;
    endfunction

    function automatic logic [1:0] predict_release(input logic [31:0] area);
        int slot;
        int pos;
        logic [31:0] s;
        logic [31:0] s2;
        logic [31:0] hdr;
        logic m_next;
        logic m_prev;
        if (area == 0) return ffha_pkg::ST_BAD_ARG;
        slot = -1;
        for (int j = USED_SLOTS - 1; j >= 0; j--)
            if (used_ok[j] && used_area[j] == area) slot = j;
        if (slot < 0) return ffha_pkg::ST_UNKNOWN;
        s = used_len[slot];
        hdr = area - HDR;
        // A block that ends at the break just lowers the break.
        if (brk == area + s) begin
            brk = brk - HDR - s;
            used_ok[slot] = 1'b0;
            return ffha_pkg::ST_OK;
        end
        pos = 0;
        while (pos < free_cnt && free_hdr[pos] < hdr) pos++;
        s2 = s;
        m_next = 1'b0;
        m_prev = 1'b0;
        if (pos < free_cnt && area + s == free_hdr[pos]
                && s + HDR + free_len[pos] <= 32'h00FF_FFFF) begin
            m_next = 1'b1;
            s2 = s + HDR + free_len[pos];
        end
        if (pos > 0 && free_hdr[pos - 1] + HDR + free_len[pos - 1] == hdr
                && free_len[pos - 1] + HDR + s2 <= 32'h00FF_FFFF)
            m_prev = 1'b1;
        if (!m_next && !m_prev && free_cnt >= FREE_SLOTS) return ffha_pkg::ST_FULL;
        used_ok[slot] = 1'b0;
        if (m_prev) begin
            free_len[pos - 1] = free_len[pos - 1] + HDR + s2;
            if (m_next) drop_free_entry(pos);
        end else if (m_next) begin
            free_hdr[pos] = hdr;
            free_len[pos] = s2;
        end else begin
            for (int i = free_cnt; i > pos; i--) begin
                free_hdr[i] = free_hdr[i - 1];
                free_len[i] = free_len[i - 1];
            end
            free_hdr[pos] = hdr;
            free_len[pos] = s;
            free_cnt++;
        end
        return ffha_pkg::ST_OK;
    endfunction

    // Compare results first, then predict the transaction taken at this edge.
    always @(posedge i_clk) begin
        t_heap_reply got;
        t_heap_reply want;
        if (!i_rst_n) begin
            free_cnt = 0;
            brk = ffha_pkg::HEAP_BASE_RESET;
            for (int k = 0; k < USED_SLOTS; k++) used_ok[k] = 1'b0;
            o_errors <= 0;
            replies_due.delete();
        end else begin
            if (i_done) begin
                if (replies_due.size() == 0) begin
                    $display("%0t: result with none expected: addr %h status %0d break %h",
                             $time, i_result_addr, i_status, i_break_addr);
                    o_errors <= o_errors + 1;
                end else begin
                    want = replies_due.pop_front();
                    if (want.area !== i_result_addr || want.status !== i_status
                            || want.brk !== i_break_addr) begin
                        $display("%0t: mismatch: expected %h/%0d/%h, got %h/%0d/%h",
                                 $time, want.area, want.status, want.brk,
                                 i_result_addr, i_status, i_break_addr);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) brk = i_cfg_data;
            if (i_start && !i_busy) begin
                got.area = '0;
                if (i_func == ffha_pkg::FUNC_ALLOC)
                    predict_alloc(i_req_size, got.area, got.status);
                else got.status = predict_release(i_release_addr);
                got.brk = brk;
                replies_due.push_back(got);
            end
        end
    end

endmodule

[bench/tb_first_fit_heap_allocator_top.sv]
// Testbench top of the heap allocator: stimulus, clock, reset and verdict.
`timescale 1ns / 1ps
module tb_first_fit_heap_allocator_top;

    localparam int CYCLE_LIMIT = 3_000_000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_start = 1'b0;
    logic        i_func = ffha_pkg::FUNC_ALLOC;
    logic [23:0] i_req_size = '0;
    logic [31:0] i_release_addr = '0;
    logic        i_cfg_valid = 1'b0;
    logic [31:0] i_cfg_data = '0;
    logic        o_busy;
    logic        o_done;
    logic [31:0] o_result_addr;
    logic [1:0]  o_status;
    logic [31:0] o_break_addr;
    logic        o_cfg_ready;
    int          errors;
    int          pending;
    int          cycles = 0;

    // Areas handed out and not yet released, and the functions in flight.
    logic [31:0] live_areas[$];
    logic        funcs_in_flight[$];
    logic [31:0] last_area;
    logic [31:0] big_area[66];

    first_fit_heap_allocator_top uut (.*);

    ffha_checker chk (
        .i_clk, .i_rst_n, .i_start, .i_busy(o_busy), .i_func, .i_req_size,
        .i_release_addr, .i_done(o_done), .i_result_addr(o_result_addr),
        .i_status(o_status), .i_break_addr(o_break_addr), .i_cfg_valid,
        .i_cfg_ready(o_cfg_ready), .i_cfg_data, .o_errors(errors), .o_pending(pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Record areas given by successful allocations.
    always @(posedge i_clk) begin
        if (o_done && funcs_in_flight.size() > 0) begin
            if (funcs_in_flight.pop_front() == ffha_pkg::FUNC_ALLOC
                    && o_status == ffha_pkg::ST_OK) begin
                live_areas.push_back(o_result_addr);
                last_area <= o_result_addr;
            end
        end
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Offers one request and holds it until the transaction is taken.
    task automatic send(input logic f, input logic [23:0] sz, input logic [31:0] ra,
                        input int gap);
        logic taken;
        @(negedge i_clk);
        i_start <= 1'b1;
        i_func <= f;
        i_req_size <= sz;
        i_release_addr <= ra;
        taken = 1'b0;
        while (!taken) begin
            #1 taken = !o_busy;
            @(posedge i_clk);
            if (!taken) @(negedge i_clk);
        end
        funcs_in_flight.push_back(f);
        if (gap > 0) begin
            @(negedge i_clk);
            i_start <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_start <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // Directed request that waits for its result.
    task automatic one(input logic f, input logic [23:0] sz, input logic [31:0] ra);
        send(f, sz, ra, 1);
        drain();
    endtask

    task automatic release_live(input int idx);
        logic [31:0] a;
        a = live_areas[idx];
        live_areas.delete(idx);
        send(ffha_pkg::FUNC_FREE, 24'($urandom), a, gap_len());
    endtask

    task automatic set_heap_base(input logic [31:0] base);
        logic taken;
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= base;
        taken = 1'b0;
        while (!taken) begin
            #1 taken = o_cfg_ready;
            @(posedge i_clk);
            @(negedge i_clk);
        end
        i_cfg_valid <= 1'b0;
    endtask

    task automatic random_item();
        int r;
        logic [23:0] sz;
        r = $urandom_range(0, 99);
        if (live_areas.size() > 0 && (r < 40 || (live_areas.size() > 50 && r < 75))) begin
            release_live($urandom_range(0, live_areas.size() - 1));
        end else if (r < 47) begin
            r = $urandom_range(0, 9);
            if (r == 0) send(ffha_pkg::FUNC_FREE, 24'($urandom), 32'd0, gap_len());
            else if (r < 3 && live_areas.size() > 0)
                send(ffha_pkg::FUNC_FREE, 24'($urandom),
                     live_areas[$urandom_range(0, live_areas.size() - 1)] + 32'd4,
                     gap_len());
            else send(ffha_pkg::FUNC_FREE, 24'($urandom), $urandom, gap_len());
        end else begin
            r = $urandom_range(0, 99);
            if (r < 70) sz = 24'($urandom_range(1, 256));
            else if (r < 92) sz = 24'($urandom_range(1, 4096));
            else if (r < 94) sz = 24'd0;
            else sz = 24'($urandom_range(0, 24'hFF_FFFF));
            send(ffha_pkg::FUNC_ALLOC, sz, $urandom, gap_len());
        end
    endtask

    initial begin
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Bad arguments, size rounding and the largest size.
        one(ffha_pkg::FUNC_ALLOC, 24'd0, '0);
        one(ffha_pkg::FUNC_ALLOC, 24'hFF_FFFD, '0);
        one(ffha_pkg::FUNC_ALLOC, 24'hFF_FFFF, '0);
        one(ffha_pkg::FUNC_FREE, '0, 32'd0);
        one(ffha_pkg::FUNC_FREE, '0, 32'hDEAD_BEEF);
        one(ffha_pkg::FUNC_ALLOC, 24'd1, '0);
        a = last_area;
        one(ffha_pkg::FUNC_ALLOC, 24'd2, '0);
        b = last_area;
        one(ffha_pkg::FUNC_ALLOC, 24'd3, '0);
        c = last_area;
        one(ffha_pkg::FUNC_ALLOC, 24'hFF_FFFC, '0);
        // Free a, then c (merges nothing), then b (merges both sides).
        one(ffha_pkg::FUNC_FREE, '0, a);
        one(ffha_pkg::FUNC_FREE, '0, c);
        one(ffha_pkg::FUNC_FREE, '0, b);
        one(ffha_pkg::FUNC_FREE, '0, b);
        // Take from the merged block with a split, then whole.
        one(ffha_pkg::FUNC_ALLOC, 24'd4, '0);
        one(ffha_pkg::FUNC_ALLOC, 24'd20, '0);
        // Block at the break lowers the break.
        one(ffha_pkg::FUNC_FREE, '0, live_areas[3]);
        live_areas.delete();

        // Fill the used table past its end, then release everything.
        set_heap_base(32'hFFFF_FF00);
        for (int k = 0; k < 66; k++) send(ffha_pkg::FUNC_ALLOC, 24'd8, '0, gap_len());
        drain();
        while (live_areas.size() > 0) release_live(0);
        drain();

        // Large adjacent blocks too big to merge fill the free table.
        set_heap_base(32'h4000_0000);
        live_areas.delete();
        for (int k = 0; k < 64; k++) begin
            one(ffha_pkg::FUNC_ALLOC, 24'h80_0000, '0);
            big_area[k] = last_area;
        end
        for (int k = 0; k < 63; k++) one(ffha_pkg::FUNC_FREE, '0, big_area[k]);
        one(ffha_pkg::FUNC_ALLOC, 24'h80_0004, '0);
        big_area[64] = last_area;
        one(ffha_pkg::FUNC_FREE, '0, big_area[63]);
        one(ffha_pkg::FUNC_ALLOC, 24'h80_0004, '0);
        big_area[65] = last_area;
        one(ffha_pkg::FUNC_FREE, '0, big_area[64]);
        one(ffha_pkg::FUNC_FREE, '0, big_area[65]);
        one(ffha_pkg::FUNC_FREE, '0, big_area[64]);
        live_areas.delete();

        // Random phases under different heap bases.
        for (int ph = 0; ph < 6; ph++) begin
            unique case (ph)
                0: set_heap_base(32'h0000_0000);
                1: set_heap_base(32'hFFFF_FFF0);
                2: set_heap_base($urandom);
                3: set_heap_base(ffha_pkg::HEAP_BASE_RESET);
                4: set_heap_base(32'hFFFF_FFFF);
                default: set_heap_base(32'h2000_0000);
            endcase
            for (int n = 0; n < 230; n++) begin
                random_item();
                if (n == 115) drain();
            end
        end
        drain();

        while (pending != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

[sim.f]
src/ffha_pkg.sv
src/ffha_ctrl.sv
src/ffha_dp.sv
src/first_fit_heap_allocator_top.sv
bench/ffha_checker.sv
bench/tb_first_fit_heap_allocator_top.sv
